### src/assert_macros.svh
// Assertion macros used by the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### src/ple_pkg.sv
// Types and constants of the positional list engine.
`default_nettype none

package ple_pkg;

  localparam int OP_W      = 4;
  localparam int POS_W     = 5;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 3;
  localparam int CNT_W     = 5;
  localparam int MAX_SHOWN = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT_AT   = 4'd0,
    OP_INSERT_HEAD = 4'd1,
    OP_INSERT_TAIL = 4'd2,
    OP_DELETE_AT   = 4'd3,
    OP_DELETE_HEAD = 4'd4,
    OP_DELETE_TAIL = 4'd5,
    OP_SEARCH      = 4'd6,
    OP_SORT        = 4'd7,
    OP_SHOW        = 4'd8
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_SRCH,
    S_SORT_SCAN,
    S_SORT_W1,
    S_SORT_W2,
    S_SHOW_RD,
    S_SHOW_LD,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

### src/positional_list_engine.sv
// Positional list engine: bounded ordered list of signed values with a sequenced store.
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------------------
//   in      | input     | in_valid, in_ready, in_operation, in_position, in_item_value
//   out     | output    | out_valid, out_ready, out_status, out_found_position,
//           |           | out_element_value, out_element_count, out_last
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Insert shifts one entry per cycle (read one, write the previous); delete shifts the same way.
// Sort is selection sort. Show reads each element shown and then loads it into the out register.
// Reset (rst_n low, synchronous) empties the list; the store itself is never cleared.
// A stalled out channel holds the last result and stops the sequencer when it must load.
`default_nettype none
`include "assert_macros.svh"

module positional_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ple_pkg::OP_W-1:0]           in_operation,
  input  logic [ple_pkg::POS_W-1:0]          in_position,
  input  logic signed [ple_pkg::VAL_W-1:0]   in_item_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ple_pkg::ST_W-1:0]           out_status,
  output logic [ple_pkg::CNT_W-1:0]          out_found_position,
  output logic signed [ple_pkg::VAL_W-1:0]   out_element_value,
  output logic [ple_pkg::CNT_W-1:0]          out_element_count,
  output logic                               out_last
);

  import ple_pkg::*;

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int AW  = $clog2(CAPACITY);
  localparam int XW0 = (CW > CNT_W) ? CW : CNT_W;
  localparam int XW  = ((XW0 > POS_W) ? XW0 : POS_W) + 1;

  // Element store and its ports
  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic signed [VAL_W-1:0] rd_data_r;

  // Sequencer registers
  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           ptr_r, ptr_nxt;
  logic                    pend_r, pend_nxt;
  logic [AW-1:0]           paddr_r, paddr_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic signed [VAL_W-1:0] min_val_r, min_val_nxt;
  logic signed [VAL_W-1:0] cur_val_r, cur_val_nxt;
  logic [AW-1:0]           min_idx_r, min_idx_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic [CNT_W-1:0]        res_fpos_r, res_fpos_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]         out_status_r, out_status_nxt;
  logic [CNT_W-1:0]        out_fpos_r, out_fpos_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;
  logic                    out_last_r, out_last_nxt;

  // Shared compare unit
  logic signed [VAL_W-1:0] cmp_b;
  logic                    cmp_eq, cmp_lt;

  logic [XW-1:0]           pos_x, cnt_x, ptr_x, idx_x, paddr_x;
  logic                    out_free, show_last, list_full;

  assign pos_x   = XW'(in_position);
  assign cnt_x   = XW'(count_r);
  assign ptr_x   = XW'(ptr_r);
  assign idx_x   = XW'(idx_r);
  assign paddr_x = XW'(paddr_r);

  assign cmp_b  = (state_r == S_SRCH) ? val_r : min_val_r;
  assign cmp_eq = (rd_data_r == cmp_b);
  assign cmp_lt = (rd_data_r < cmp_b);

  assign out_free  = !out_valid_r || out_ready;
  assign list_full = (count_r == CW'(CAPACITY));
  assign show_last = (ptr_x + XW'(1) == cnt_x) || (ptr_x == XW'(MAX_SHOWN - 1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    ptr_r        <= ptr_nxt;
    paddr_r      <= paddr_nxt;
    val_r        <= val_nxt;
    min_val_r    <= min_val_nxt;
    cur_val_r    <= cur_val_nxt;
    min_idx_r    <= min_idx_nxt;
    res_status_r <= res_status_nxt;
    res_fpos_r   <= res_fpos_nxt;
    out_status_r <= out_status_nxt;
    out_fpos_r   <= out_fpos_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = 1'b0;
    paddr_nxt      = paddr_r;
    val_nxt        = val_r;
    min_val_nxt    = min_val_r;
    cur_val_nxt    = cur_val_r;
    min_idx_nxt    = min_idx_r;
    res_status_nxt = res_status_r;
    res_fpos_nxt   = res_fpos_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_fpos_nxt   = out_fpos_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    in_ready       = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          val_nxt        = in_item_value;
          res_status_nxt = ST_OK;
          res_fpos_nxt   = '0;
          ptr_nxt        = '0;
          state_nxt      = S_RESP;
          case (in_operation)
            OP_INSERT_AT: begin
              if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                res_status_nxt = ST_BADPOS;
              end else if (list_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                idx_nxt   = CW'(pos_x - XW'(1));
                ptr_nxt   = count_r;
                state_nxt = S_INS;
              end
            end
            OP_INSERT_HEAD, OP_INSERT_TAIL: begin
              if (list_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                idx_nxt   = (in_operation == OP_INSERT_HEAD) ? '0 : count_r;
                ptr_nxt   = count_r;
                state_nxt = S_INS;
              end
            end
            OP_DELETE_AT: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else if (pos_x == '0 || pos_x > cnt_x) begin
                res_status_nxt = ST_BADPOS;
              end else begin
                idx_nxt   = CW'(pos_x - XW'(1));
                ptr_nxt   = CW'(pos_x - XW'(1));
                state_nxt = S_DEL;
              end
            end
            OP_DELETE_HEAD, OP_DELETE_TAIL: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                idx_nxt   = (in_operation == OP_DELETE_HEAD) ? '0 : count_r - CW'(1);
                ptr_nxt   = (in_operation == OP_DELETE_HEAD) ? '0 : count_r - CW'(1);
                state_nxt = S_DEL;
              end
            end
            OP_SEARCH: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            OP_SORT: begin
              if (cnt_x > XW'(1)) begin
                idx_nxt   = '0;
                state_nxt = S_SORT_SCAN;
              end
            end
            OP_SHOW: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SHOW_RD;
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end

      // Move entries up one place, top first; the read of the next source overlaps the write.
      S_INS: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = paddr_r;
          mem_wdata = rd_data_r;
        end
        if (ptr_r > idx_r) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr_r - CW'(1));
          pend_nxt  = 1'b1;
          paddr_nxt = AW'(ptr_r);
          ptr_nxt   = ptr_r - CW'(1);
        end else if (!pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(idx_r);
          mem_wdata = val_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_RESP;
        end
      end

      // Move entries down one place, bottom first.
      S_DEL: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = paddr_r;
          mem_wdata = rd_data_r;
        end
        if (ptr_x + XW'(1) < cnt_x) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr_r + CW'(1));
          pend_nxt  = 1'b1;
          paddr_nxt = AW'(ptr_r);
          ptr_nxt   = ptr_r + CW'(1);
        end else if (!pend_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_SRCH: begin
        if (pend_r && cmp_eq) begin
          res_status_nxt = ST_OK;
          res_fpos_nxt   = CNT_W'(paddr_x + XW'(1));
          state_nxt      = S_RESP;
        end else if (ptr_r < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr_r);
          pend_nxt  = 1'b1;
          paddr_nxt = AW'(ptr_r);
          ptr_nxt   = ptr_r + CW'(1);
        end else if (!pend_r) begin
          res_status_nxt = ST_NOTFOUND;
          state_nxt      = S_RESP;
        end
      end

      // Scan entries idx..count-1 for the minimum; the first one read seeds it.
      S_SORT_SCAN: begin
        if (pend_r) begin
          if (paddr_r == AW'(idx_r)) begin
            cur_val_nxt = rd_data_r;
            min_val_nxt = rd_data_r;
            min_idx_nxt = paddr_r;
          end else if (cmp_lt) begin
            min_val_nxt = rd_data_r;
            min_idx_nxt = paddr_r;
          end
        end
        if (ptr_r < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr_r);
          pend_nxt  = 1'b1;
          paddr_nxt = AW'(ptr_r);
          ptr_nxt   = ptr_r + CW'(1);
        end else if (!pend_r) begin
          state_nxt = S_SORT_W1;
        end
      end

      S_SORT_W1: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r);
        mem_wdata = min_val_r;
        state_nxt = S_SORT_W2;
      end

      S_SORT_W2: begin
        mem_we    = 1'b1;
        mem_waddr = min_idx_r;
        mem_wdata = cur_val_r;
        if (idx_x + XW'(2) >= cnt_x) begin
          state_nxt = S_RESP;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          ptr_nxt   = idx_r + CW'(1);
          state_nxt = S_SORT_SCAN;
        end
      end

      S_SHOW_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(ptr_r);
        state_nxt = S_SHOW_LD;
      end

      // Hold the read data until the output register is free.
      S_SHOW_LD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_fpos_nxt   = CNT_W'(ptr_x + XW'(1));
          out_value_nxt  = rd_data_r;
          out_count_nxt  = cnt_x[CNT_W-1:0];
          out_last_nxt   = show_last;
          if (show_last) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_r + CW'(1);
            state_nxt = S_SHOW_RD;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_fpos_nxt   = res_fpos_r;
          out_value_nxt  = '0;
          out_count_nxt  = cnt_x[CNT_W-1:0];
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_fpos_r;
  assign out_element_value  = out_value_r;
  assign out_element_count  = out_count_r;
  assign out_last           = out_last_r;

  `ASSERT_IMPL(a_count_in_range, 1'b1, count_r <= CW'(CAPACITY))
  `ASSERT_IMPL(a_idle_count_stable, state_r == S_IDLE, count_nxt == count_r)
  `ASSERT_IMPL(a_write_state,
    mem_we,
    state_r == S_INS || state_r == S_DEL || state_r == S_SORT_W1 || state_r == S_SORT_W2)
  `ASSERT_NEXT(a_full_insert,
    in_valid && in_ready && list_full &&
      (in_operation == OP_INSERT_HEAD || in_operation == OP_INSERT_TAIL),
    state_r == S_RESP && res_status_r == ST_FULL && $stable(count_r))

endmodule

`default_nettype wire
